FILE: rtl/door_command_reconciler_defines.svh
// Assertion macros shared by the door command reconciler RTL.
`ifndef DOOR_COMMAND_RECONCILER_DEFINES_SVH
`define DOOR_COMMAND_RECONCILER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DCR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DCR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dcr_pkg.sv
// Types, codes and constants of the door command reconciler.
package dcr_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int DOORS_DEF = 8;

    localparam int MODE_W = 2;
    localparam int DOOR_W = 3;
    localparam int SLOT_W = 5;
    localparam int OBS_W = 3;
    localparam int OUT_SLOT_W = 4;
    localparam int TICK_W = 4;
    localparam int RETRY_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_DOOR  = 2'd0,
        MODE_SET_SLOT  = 2'd1,
        MODE_RECONCILE = 2'd2,
        MODE_QUERY     = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_CLOSED = 2'd2;

    localparam logic [OBS_W-1:0] OBS_UNKNOWN = 3'd2;
    localparam logic [OBS_W-1:0] OBS_OPEN = 3'd3;
    localparam logic [OBS_W-1:0] OBS_CLOSED = 3'd4;

    localparam logic [1:0] D_UNSET = 2'd3;
    localparam logic [1:0] D_OPEN = 2'd1;
    localparam logic [1:0] C_OPEN = 2'd1;
    localparam logic [1:0] C_NEVER = 2'd2;

    localparam logic [TICK_W-1:0] TICK_MAX = 4'd15;

    localparam logic [TICK_W-1:0] RETRY_TICKS_RST = 4'd5;
    localparam logic [RETRY_W-1:0] MAX_ATTEMPTS_RST = 3'd2;

    typedef struct packed {
        logic [TICK_W-1:0]  retry_ticks;
        logic [RETRY_W-1:0] max_attempts;
        logic               baseline_closed;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [DOOR_W-1:0]        door;
        logic signed [SLOT_W-1:0] slot;
        logic                     want_open;
        logic [OBS_W-1:0]         observation;
    } req_t;

    typedef struct packed {
        logic                  toggle;
        logic [OUT_SLOT_W-1:0] out_slot;
        logic                  stuck;
        logic                  ignored;
    } rsp_t;

    typedef struct packed {
        logic [1:0]         desired;
        logic [1:0]         commanded;
        logic [TICK_W-1:0]  ticks;
        logic [RETRY_W-1:0] retries;
    } slot_entry_t;

    typedef struct packed {
        logic                  valid;
        logic [OUT_SLOT_W-1:0] slot;
    } door_entry_t;

    localparam slot_entry_t SLOT_ENTRY_RST = '{
        desired: D_UNSET, commanded: C_NEVER, ticks: '0, retries: '0};
    localparam door_entry_t DOOR_ENTRY_RST = '{valid: 1'b0, slot: '0};

endpackage

FILE: rtl/dcr_ifs.sv
// Command and result channel interfaces of the door command reconciler.
interface dcr_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [dcr_pkg::MODE_W-1:0]          mode;
    logic [dcr_pkg::DOOR_W-1:0]          door;
    logic signed [dcr_pkg::SLOT_W-1:0]   slot;
    logic                                want_open;
    logic [dcr_pkg::OBS_W-1:0]           observation;

    modport source (output valid, mode, door, slot, want_open, observation, input ready);
    modport sink (input valid, mode, door, slot, want_open, observation, output ready);
endinterface

interface dcr_res_if;
    logic                                valid;
    logic                                ready;
    logic                                toggle;
    logic [dcr_pkg::OUT_SLOT_W-1:0]      out_slot;
    logic                                stuck;
    logic                                ignored;

    modport source (output valid, toggle, out_slot, stuck, ignored, input ready);
    modport sink (input valid, toggle, out_slot, stuck, ignored, output ready);
endinterface

FILE: rtl/dcr_engine.sv
// Per-slot and per-door state store with the combinational command and reconcile logic.
`include "door_command_reconciler_defines.svh"

module dcr_engine #(
    parameter int SLOTS = dcr_pkg::SLOTS_DEF,
    parameter int DOORS = dcr_pkg::DOORS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dcr_pkg::cfg_t  cfg,
    input  logic           fire,
    input  dcr_pkg::req_t  req,
    output dcr_pkg::rsp_t  rsp
);

    // The slot field reaches 0 to 15 and the door field 0 to 7, so deeper stores are never used.
    localparam int SLOT_DEPTH = (SLOTS < 16) ? SLOTS : 16;
    localparam int DOOR_DEPTH = (DOORS < 8) ? DOORS : 8;
    localparam int SIDX_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int DIDX_W = (DOOR_DEPTH > 1) ? $clog2(DOOR_DEPTH) : 1;

    dcr_pkg::slot_entry_t slot_reg [SLOT_DEPTH];
    dcr_pkg::door_entry_t door_reg [DOOR_DEPTH];

    dcr_pkg::mode_t                     mode;
    logic                               door_ok;
    logic [DIDX_W-1:0]                  didx;
    dcr_pkg::door_entry_t               rem;
    logic signed [dcr_pkg::SLOT_W-1:0]  used;
    logic                               used_ok;
    logic [SIDX_W-1:0]                  sidx;
    dcr_pkg::slot_entry_t               entry;
    logic                               c_known;
    logic                               c_open;
    logic                               d_set;
    logic                               want;
    logic                               obs_known;
    logic                               obs_act;
    logic                               is_open;
    logic [dcr_pkg::TICK_W-1:0]         tick_inc;
    logic                               slot_we;
    dcr_pkg::slot_entry_t               slot_next;
    logic                               door_we;
    dcr_pkg::door_entry_t               door_next;
    logic                               toggle;
    logic                               stuck;
    logic                               ignored;

    always_comb
    begin
        mode = dcr_pkg::mode_t'(req.mode);
        door_ok = 32'(req.door) < DOORS;
        didx = req.door[DIDX_W-1:0];
        rem = door_reg[didx];
        used = req.slot;
        if (mode == dcr_pkg::MODE_SET_DOOR && door_ok && !req.want_open && rem.valid)
        begin
            used = {1'b0, rem.slot};
        end
        used_ok = !used[dcr_pkg::SLOT_W-1] && (32'(used[dcr_pkg::OUT_SLOT_W-1:0]) < SLOTS);
        sidx = used[SIDX_W-1:0];
        entry = slot_reg[sidx];

        c_known = (entry.commanded != dcr_pkg::C_NEVER) || cfg.baseline_closed;
        c_open = entry.commanded == dcr_pkg::C_OPEN;
        d_set = entry.desired != dcr_pkg::D_UNSET;
        want = entry.desired[0];
        obs_known = req.observation != dcr_pkg::OBS_UNKNOWN;
        obs_act = (req.observation == dcr_pkg::OBS_UNKNOWN)
            || (req.observation == dcr_pkg::OBS_OPEN)
            || (req.observation == dcr_pkg::OBS_CLOSED);
        is_open = obs_known ? (req.observation == dcr_pkg::OBS_OPEN) : (c_known && c_open);
        tick_inc = (entry.ticks != dcr_pkg::TICK_MAX) ? entry.ticks + 4'd1 : entry.ticks;

        slot_we = 1'b0;
        slot_next = entry;
        door_we = 1'b0;
        door_next = rem;
        toggle = 1'b0;
        stuck = 1'b0;
        ignored = 1'b0;

        unique case (mode)
            dcr_pkg::MODE_SET_DOOR:
            begin
                if (!door_ok || !used_ok)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    slot_we = 1'b1;
                    slot_next.desired = {1'b0, req.want_open};
                    door_we = 1'b1;
                    door_next.valid = req.want_open;
                    door_next.slot = used[dcr_pkg::OUT_SLOT_W-1:0];
                end
            end
            dcr_pkg::MODE_SET_SLOT:
            begin
                if (!used_ok)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    slot_we = 1'b1;
                    slot_next.desired = {1'b0, req.want_open};
                end
            end
            dcr_pkg::MODE_QUERY:
            begin
                if (!used_ok)
                begin
                    ignored = 1'b1;
                end
                else
                begin
                    stuck = (entry.desired == dcr_pkg::D_OPEN)
                        && (entry.retries >= cfg.max_attempts);
                end
            end
            dcr_pkg::MODE_RECONCILE:
            begin
                if (!used_ok)
                begin
                    ignored = 1'b1;
                end
                else if (d_set && obs_act)
                begin
                    slot_we = 1'b1;
                    if (!(c_known && (c_open == want)))
                    begin
                        slot_next.commanded = {1'b0, want};
                        slot_next.ticks = '0;
                        slot_next.retries = '0;
                        toggle = is_open != want;
                    end
                    else if (!obs_known || (is_open == want))
                    begin
                        slot_next.retries = '0;
                    end
                    else if ((tick_inc >= cfg.retry_ticks)
                        && (entry.retries < cfg.max_attempts))
                    begin
                        slot_next.ticks = '0;
                        slot_next.retries = entry.retries + 3'd1;
                        toggle = 1'b1;
                    end
                    else
                    begin
                        slot_next.ticks = tick_inc;
                    end
                end
            end
            default:
            begin
                ignored = 1'b1;
            end
        endcase

        rsp.toggle = toggle;
        rsp.out_slot = ignored ? '0 : used[dcr_pkg::OUT_SLOT_W-1:0];
        rsp.stuck = stuck;
        rsp.ignored = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_DEPTH; i++)
            begin
                slot_reg[i] <= dcr_pkg::SLOT_ENTRY_RST;
            end
        end
        else if (fire && slot_we)
        begin
            slot_reg[sidx] <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DOOR_DEPTH; i++)
            begin
                door_reg[i] <= dcr_pkg::DOOR_ENTRY_RST;
            end
        end
        else if (fire && door_we)
        begin
            door_reg[didx] <= door_next;
        end
    end

    `DCR_ASSERT_IMP(a_ignored_clean, clk, rst_n, fire && rsp.ignored, !rsp.toggle && !rsp.stuck && (rsp.out_slot == '0) && !slot_we && !door_we)
    `DCR_ASSERT_NXT(a_toggle_clears_ticks, clk, rst_n, fire && rsp.toggle, slot_reg[$past(sidx)].ticks == '0)
    `DCR_ASSERT_IMP(a_stuck_only_query, clk, rst_n, rsp.stuck, mode == dcr_pkg::MODE_QUERY)

endmodule

FILE: rtl/door_command_reconciler.sv
// Door command reconciler: one command beat in, one result beat out, one beat per clock unless
// the result side stalls. Every accepted command beat gives exactly one result beat when the
// result side is ready: the beat is held in an input register, the slot and door state is read,
// decided and written back while the result is captured in the output register. A new command
// beat can be taken every cycle unless the result side stalls, and a command on the same slot
// as the one just before it sees the updated state, because the state store is written in the
// same cycle that the result register is loaded. The result register is the only stall point.
// The state comes out of reset already in its initial form; there is no clearing pass.
module door_command_reconciler #(
    parameter int SLOTS = dcr_pkg::SLOTS_DEF,
    parameter int DOORS = dcr_pkg::DOORS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dcr_cmd_if.sink                           cmd,
    dcr_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [dcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    dcr_pkg::cfg_t  cfg_reg;
    logic           cmd_valid_reg;
    dcr_pkg::req_t  cmd_reg;
    logic           res_valid_reg;
    dcr_pkg::rsp_t  res_reg;
    dcr_pkg::rsp_t  rsp;
    logic           fire;

    assign fire = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_ticks <= dcr_pkg::RETRY_TICKS_RST;
            cfg_reg.max_attempts <= dcr_pkg::MAX_ATTEMPTS_RST;
            cfg_reg.baseline_closed <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcr_pkg::CFG_RETRY_TICKS:
                begin
                    cfg_reg.retry_ticks <= cfg_wdata[dcr_pkg::TICK_W-1:0];
                end
                dcr_pkg::CFG_MAX_ATTEMPTS:
                begin
                    cfg_reg.max_attempts <= cfg_wdata[dcr_pkg::RETRY_W-1:0];
                end
                dcr_pkg::CFG_BASELINE_CLOSED:
                begin
                    cfg_reg.baseline_closed <= cfg_wdata[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.mode <= cmd.mode;
            cmd_reg.door <= cmd.door;
            cmd_reg.slot <= cmd.slot;
            cmd_reg.want_open <= cmd.want_open;
            cmd_reg.observation <= cmd.observation;
        end
    end

    dcr_engine #(
        .SLOTS (SLOTS),
        .DOORS (DOORS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .fire  (fire),
        .req   (cmd_reg),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= rsp;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.toggle = res_reg.toggle;
    assign res.out_slot = res_reg.out_slot;
    assign res.stuck = res_reg.stuck;
    assign res.ignored = res_reg.ignored;

endmodule
